[rtl/cbpc_pkg.sv]
// ----------------------------------------------------------------------------
// cbpc_pkg
// Shared constants and types for the CMYK / BGRA pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpc_pkg;

	localparam int unsigned LaneW = 8;
	localparam int unsigned PctW  = 7;
	localparam int unsigned NumW  = 15;
	localparam int unsigned AddrW = 3;

	localparam logic [PctW-1:0]  Percent  = 7'd100;
	localparam logic [LaneW-1:0] FullByte = 8'd255;
	localparam logic [15:0]      FullSq   = 16'd65025;

	// register map
	localparam logic [AddrW-1:0] DirAddr = 3'd0;

	// direction codes
	localparam logic DirToBgra = 1'b0;
	localparam logic DirToCmyk = 1'b1;

	// floor(n / 10000) for n < 2**22 as (n * recip) >> 36; 255 folded in
	localparam int unsigned      ChanShift = 36;
	localparam longint unsigned  ChanRecip = ((64'd1 << ChanShift) / 10000) + 1;
	localparam logic [30:0]      ChanMul   = 31'(255 * ChanRecip);

	// floor(n / 65025) for n < 2**23 as (n * recip) >> 39; 100 folded in
	localparam int unsigned      KShift = 39;
	localparam longint unsigned  KRecip = ((64'd1 << KShift) / 65025) + 1;
	localparam logic [29:0]      KMul   = 30'(100 * KRecip);

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

`default_nettype wire

[rtl/cbpc_if.sv]
// ----------------------------------------------------------------------------
// cbpc_if
// Valid/ready channels carrying one packed pixel each.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] lane0;
	logic [7:0] lane1;
	logic [7:0] lane2;
	logic [7:0] lane3;

	modport source (output valid, output lane0, output lane1, output lane2, output lane3,
		input ready);
	modport sink (input valid, input lane0, input lane1, input lane2, input lane3,
		output ready);
endinterface

interface cbpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] res0;
	logic [7:0] res1;
	logic [7:0] res2;
	logic [7:0] res3;

	modport source (output valid, output res0, output res1, output res2, output res3,
		input ready);
	modport sink (input valid, input res0, input res1, input res2, input res3,
		output ready);
endinterface

`default_nettype wire

[rtl/cbpc_pct_div.sv]
// ----------------------------------------------------------------------------
// cbpc_pct_div
// Pipelined restoring divider: seven quotient bits over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpc_pct_div (
	input  wire logic                         clk,
	input  wire cbpc_pkg::stage_en_t          en,
	input  wire logic [cbpc_pkg::NumW-1:0]    num,
	input  wire logic [cbpc_pkg::LaneW-1:0]   mx,
	output logic      [cbpc_pkg::PctW-1:0]    q
);
	import cbpc_pkg::*;

	logic [NumW-1:0]  rem_a, rem_b, rem_s2, rem_s3;
	logic [PctW-1:0]  q_a, q_b, q_c, q_s2, q_s3, q_s4;
	logic [LaneW-1:0] mx_s2, mx_s3;

	// quotient bits 6..4
	always_comb begin
		rem_a = num;
		q_a   = '0;
		for (int i = 6; i >= 4; i--) begin
			if (rem_a >= (NumW'(mx) << i)) begin
				rem_a        = rem_a - (NumW'(mx) << i);
				q_a[3'(i)]   = 1'b1;
			end
		end
	end

	// quotient bits 3..1
	always_comb begin
		rem_b = rem_s2;
		q_b   = q_s2;
		for (int i = 3; i >= 1; i--) begin
			if (rem_b >= (NumW'(mx_s2) << i)) begin
				rem_b        = rem_b - (NumW'(mx_s2) << i);
				q_b[3'(i)]   = 1'b1;
			end
		end
	end

	// quotient bit 0
	always_comb begin
		q_c = q_s3;
		if (rem_s3 >= NumW'(mx_s3)) begin
			q_c[0] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			rem_s2 <= rem_a;
			q_s2   <= q_a;
			mx_s2  <= mx;
		end
		if (en.s3) begin
			rem_s3 <= rem_b;
			q_s3   <= q_b;
			mx_s3  <= mx_s2;
		end
		if (en.s4) begin
			q_s4 <= q_c;
		end
	end

	assign q = q_s4;

endmodule

`default_nettype wire

[rtl/cmyk_bgra_pixel_converter.sv]
// ----------------------------------------------------------------------------
// cmyk_bgra_pixel_converter
// Converts percent CMYK pixels to BGRA, or BGRA to percent CMYK.
// ----------------------------------------------------------------------------
// Requests pass through registered stages s1 to s4 on the way to the output.
// Throughput: one pixel per cycle; each of the four stages holds on its own,
// so a stalled output fills bubbles upstream before the input stalls.
// Reset: valid bits clear and direction returns to CMYK-to-BGRA.
`default_nettype none

module cmyk_bgra_pixel_converter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	cbpc_in_if.sink                          pixels,
	cbpc_out_if.source                       results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [cbpc_pkg::AddrW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import cbpc_pkg::*;

	logic dir_q;

	logic      en1;
	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      dir_s1, dir_s2, dir_s3, dir_s4;

	// stage 1
	logic [PctW-1:0]  k_c;
	logic [PctW-1:0]  x_c [3];
	logic [LaneW-1:0] mx_c;
	logic [PctW-1:0]  dk_s1;
	logic [PctW-1:0]  dx_s1 [3];
	logic [LaneW-1:0] mx_s1;
	logic [15:0]      p_s1;
	logic [NumW-1:0]  num_s1 [3];

	// stage 2
	logic [13:0] prod_s2 [3];
	logic [15:0] w_s2;
	logic        zero_s2;

	// stage 3
	logic [47:0] chan_s3 [3];
	logic [47:0] k_s3;
	logic        zero_s3;

	// stage 4
	logic [LaneW-1:0] chan_s4 [3];
	logic [PctW-1:0]  k_s4;
	logic             zero_s4;
	logic [PctW-1:0]  pct_q [3];

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DirToBgra;
		end else if (psel && penable && pwrite && pready && paddr == DirAddr) begin
			dir_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == DirAddr) ? 32'(dir_q) : 32'd0;

	// stage enables
	assign en.s4 = !v_s4 || results.ready;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en1   = !v_s1 || en.s2;
	assign pixels.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)   v_s1 <= pixels.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// saturate percents, find the brightest channel
	always_comb begin
		k_c    = (pixels.lane0 > 8'(Percent)) ? Percent : pixels.lane0[PctW-1:0];
		x_c[0] = (pixels.lane1 > 8'(Percent)) ? Percent : pixels.lane1[PctW-1:0];
		x_c[1] = (pixels.lane2 > 8'(Percent)) ? Percent : pixels.lane2[PctW-1:0];
		x_c[2] = (pixels.lane3 > 8'(Percent)) ? Percent : pixels.lane3[PctW-1:0];
		mx_c   = pixels.lane0;
		if (pixels.lane1 > mx_c) mx_c = pixels.lane1;
		if (pixels.lane2 > mx_c) mx_c = pixels.lane2;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dir_s1    <= dir_q;
			dk_s1     <= Percent - k_c;
			for (int i = 0; i < 3; i++) begin
				dx_s1[i] <= Percent - x_c[i];
			end
			mx_s1     <= mx_c;
			p_s1      <= 16'(mx_c) * 16'(pixels.lane3);
			num_s1[0] <= NumW'(Percent) * NumW'(mx_c - pixels.lane0);
			num_s1[1] <= NumW'(Percent) * NumW'(mx_c - pixels.lane1);
			num_s1[2] <= NumW'(Percent) * NumW'(mx_c - pixels.lane2);
		end
		if (en.s2) begin
			dir_s2  <= dir_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= 14'(dx_s1[i]) * 14'(dk_s1);
			end
			w_s2    <= FullSq - p_s1;
			zero_s2 <= (p_s1 == 16'd0);
		end
		if (en.s3) begin
			dir_s3  <= dir_s2;
			for (int i = 0; i < 3; i++) begin
				chan_s3[i] <= 48'(prod_s2[i]) * 48'(ChanMul);
			end
			k_s3    <= 48'(w_s2) * 48'(KMul);
			zero_s3 <= zero_s2;
		end
		if (en.s4) begin
			dir_s4  <= dir_s3;
			for (int i = 0; i < 3; i++) begin
				chan_s4[i] <= chan_s3[i][43:36];
			end
			k_s4    <= k_s3[45:39];
			zero_s4 <= zero_s3;
		end
	end

	// percent of each colour below the brightest channel
	for (genvar g = 0; g < 3; g++) begin : g_div
		cbpc_pct_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s1[g]),
			.mx  (mx_s1),
			.q   (pct_q[g])
		);
	end

	// output select
	assign results.valid = v_s4;
	assign results.res0  = (dir_s4 == DirToCmyk) ? LaneW'(k_s4) : chan_s4[0];
	assign results.res1  = (dir_s4 == DirToBgra) ? chan_s4[1] :
		(zero_s4 ? 8'd0 : LaneW'(pct_q[0]));
	assign results.res2  = (dir_s4 == DirToBgra) ? chan_s4[2] :
		(zero_s4 ? 8'd0 : LaneW'(pct_q[1]));
	assign results.res3  = (dir_s4 == DirToBgra) ? FullByte :
		(zero_s4 ? 8'd0 : LaneW'(pct_q[2]));

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input held back with a free stage");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && dir_s4 == DirToCmyk) |-> (results.res0 <= 8'(Percent)))
		else $error("black percent above full scale");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && dir_s4 == DirToCmyk && !zero_s4) |->
		(pct_q[0] <= Percent && pct_q[1] <= Percent && pct_q[2] <= Percent))
		else $error("colour percent above full scale");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && dir_s4 == DirToCmyk && zero_s4) |->
		(results.res0 == 8'(Percent) && results.res1 == 8'd0 &&
		 results.res2 == 8'd0 && results.res3 == 8'd0))
		else $error("black or transparent pixel not mapped to pure black");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en.s4) |=> v_s4)
		else $error("request dropped between stages");

endmodule

`default_nettype wire
